FILE: hw/rtl/tvp_pkg.sv
package tvp_pkg;

   localparam int COORD_W   = 32;
   localparam int DIFF_W    = 33;
   localparam int TRIG_W    = 16;
   localparam int PROD_W    = 49;
   localparam int SUM_W     = 50;
   localparam int ROT_W     = 36;
   localparam int AXIS_W    = 37;
   localparam int DEN_W     = 37;
   localparam int NUM_W     = 50;
   localparam int SCALE_W   = 14;
   localparam int YAW_BITS  = 14;
   localparam int DIV_STEPS = 32;
   localparam int DIV_LAT   = DIV_STEPS + 2;
   localparam int XFORM_LAT = 4;
   localparam int WIN_W     = 40;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_CAMERA_X   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAMERA_Y   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CAMERA_Z   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_YAW_COSINE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_YAW_SINE   = 3'd4;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [TRIG_W-1:0]  trig_type;
   typedef logic signed [DIFF_W-1:0]  diff_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [SUM_W-1:0]   sum_type;
   typedef logic signed [ROT_W-1:0]   rot_type;
   typedef logic signed [AXIS_W-1:0]  axis_type;
   typedef logic signed [DEN_W-1:0]   den_type;
   typedef logic signed [NUM_W-1:0]   num_type;
   typedef logic signed [SCALE_W-1:0] scale_type;

   typedef struct packed {
      coord_type vertex_a_x;
      coord_type vertex_a_y;
      coord_type vertex_a_z;
      coord_type vertex_b_x;
      coord_type vertex_b_y;
      coord_type vertex_b_z;
      coord_type vertex_c_x;
      coord_type vertex_c_y;
      coord_type vertex_c_z;
   } req_type;

   typedef struct packed {
      coord_type screen_a_x;
      coord_type screen_a_y;
      coord_type screen_b_x;
      coord_type screen_b_y;
      coord_type screen_c_x;
      coord_type screen_c_y;
      logic      behind_camera;
      logic      in_view;
   } rsp_type;

   typedef struct packed {
      coord_type camera_x;
      coord_type camera_y;
      coord_type camera_z;
      trig_type  yaw_cosine;
      trig_type  yaw_sine;
   } cfg_type;

   typedef struct packed {
      num_type num_x;
      num_type num_y;
      den_type den;
   } proj_type;

   typedef struct packed {
      logic       behind;
      logic [2:0] zero_den;
   } side_type;

endpackage

FILE: hw/rtl/tvp_xform.sv
module tvp_xform #(
   parameter int SCREEN_WIDTH  = 600,
   parameter int SCREEN_HEIGHT = 600
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  tvp_pkg::req_type   in_data,
   input  tvp_pkg::cfg_type   cfg,
   output logic               out_valid,
   output tvp_pkg::proj_type  out_proj [3],
   output tvp_pkg::side_type  out_side
);

   localparam tvp_pkg::scale_type W_K = tvp_pkg::scale_type'(SCREEN_WIDTH);
   localparam tvp_pkg::scale_type H_K = tvp_pkg::scale_type'(SCREEN_HEIGHT);

   tvp_pkg::coord_type vx [3];
   tvp_pkg::coord_type vy [3];
   tvp_pkg::coord_type vz [3];

   // stage 1: translate
   tvp_pkg::diff_type dx_in [3], dx_ff [3];
   tvp_pkg::diff_type py_in [3], py_ff [3];
   tvp_pkg::diff_type dz_in [3], dz_ff [3];
   // stage 2: rotation products
   tvp_pkg::prod_type xc_in [3], xc_ff [3];
   tvp_pkg::prod_type zs_in [3], zs_ff [3];
   tvp_pkg::prod_type zc_in [3], zc_ff [3];
   tvp_pkg::prod_type xs_in [3], xs_ff [3];
   tvp_pkg::diff_type py2_ff [3];
   // stage 3: rotated point, numerators before scaling
   tvp_pkg::sum_type  sx_c [3], sz_c [3];
   tvp_pkg::rot_type  rx_c [3], rz_c [3];
   tvp_pkg::axis_type hx_in [3], hx_ff [3];
   tvp_pkg::axis_type hy_in [3], hy_ff [3];
   tvp_pkg::den_type  den_in [3], den_ff [3];
   logic [2:0]        pos_in, pos_ff, zero_in, zero_ff;
   // stage 4: scaled numerators
   tvp_pkg::proj_type proj_in [3], proj_ff [3];
   tvp_pkg::side_type side_in, side_ff;

   logic v1_ff, v2_ff, v3_ff, v4_ff;

   always_comb begin
      vx[0] = in_data.vertex_a_x; vy[0] = in_data.vertex_a_y; vz[0] = in_data.vertex_a_z;
      vx[1] = in_data.vertex_b_x; vy[1] = in_data.vertex_b_y; vz[1] = in_data.vertex_b_z;
      vx[2] = in_data.vertex_c_x; vy[2] = in_data.vertex_c_y; vz[2] = in_data.vertex_c_z;
      for (int v = 0; v < 3; v++) begin
         dx_in[v] = tvp_pkg::DIFF_W'(vx[v]) - tvp_pkg::DIFF_W'(cfg.camera_x);
         py_in[v] = tvp_pkg::DIFF_W'(vy[v]) - tvp_pkg::DIFF_W'(cfg.camera_y);
         dz_in[v] = tvp_pkg::DIFF_W'(vz[v]) - tvp_pkg::DIFF_W'(cfg.camera_z);

         xc_in[v] = tvp_pkg::PROD_W'(dx_ff[v]) * tvp_pkg::PROD_W'(cfg.yaw_cosine);
         zs_in[v] = tvp_pkg::PROD_W'(dz_ff[v]) * tvp_pkg::PROD_W'(cfg.yaw_sine);
         zc_in[v] = tvp_pkg::PROD_W'(dz_ff[v]) * tvp_pkg::PROD_W'(cfg.yaw_cosine);
         xs_in[v] = tvp_pkg::PROD_W'(dx_ff[v]) * tvp_pkg::PROD_W'(cfg.yaw_sine);

         sx_c[v] = tvp_pkg::SUM_W'(xc_ff[v]) + tvp_pkg::SUM_W'(zs_ff[v]);
         sz_c[v] = tvp_pkg::SUM_W'(zc_ff[v]) - tvp_pkg::SUM_W'(xs_ff[v]);
         // arithmetic shift floors towards minus infinity
         rx_c[v] = tvp_pkg::ROT_W'(sx_c[v] >>> tvp_pkg::YAW_BITS);
         rz_c[v] = tvp_pkg::ROT_W'(sz_c[v] >>> tvp_pkg::YAW_BITS);
         hx_in[v]  = tvp_pkg::AXIS_W'(rx_c[v]) - tvp_pkg::AXIS_W'(rz_c[v]);
         hy_in[v]  = -tvp_pkg::AXIS_W'(rz_c[v]) - tvp_pkg::AXIS_W'(py2_ff[v]);
         den_in[v] = -(tvp_pkg::DEN_W'(rz_c[v]) <<< 1);
         zero_in[v] = (rz_c[v] == '0);
         pos_in[v]  = !rz_c[v][tvp_pkg::ROT_W-1] && (rz_c[v] != '0);

         proj_in[v].num_x = tvp_pkg::NUM_W'(hx_ff[v]) * tvp_pkg::NUM_W'(W_K);
         proj_in[v].num_y = tvp_pkg::NUM_W'(hy_ff[v]) * tvp_pkg::NUM_W'(H_K);
         proj_in[v].den   = den_ff[v];
      end
      side_in.behind   = |pos_ff;
      side_in.zero_den = zero_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int v = 0; v < 3; v++) begin
         dx_ff[v]   <= dx_in[v];
         py_ff[v]   <= py_in[v];
         dz_ff[v]   <= dz_in[v];
         xc_ff[v]   <= xc_in[v];
         zs_ff[v]   <= zs_in[v];
         zc_ff[v]   <= zc_in[v];
         xs_ff[v]   <= xs_in[v];
         py2_ff[v]  <= py_ff[v];
         hx_ff[v]   <= hx_in[v];
         hy_ff[v]   <= hy_in[v];
         den_ff[v]  <= den_in[v];
         proj_ff[v] <= proj_in[v];
      end
      pos_ff  <= pos_in;
      zero_ff <= zero_in;
      side_ff <= side_in;
   end

   assign out_valid = v4_ff;
   assign out_proj  = proj_ff;
   assign out_side  = side_ff;

endmodule

FILE: hw/rtl/tvp_divider.sv
module tvp_divider #(
   parameter int FRACTION_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  tvp_pkg::num_type   num,
   input  tvp_pkg::den_type   den,
   output logic               out_valid,
   output tvp_pkg::coord_type quo
);

   localparam int STEPS    = tvp_pkg::DIV_STEPS;
   localparam int NUM_W    = tvp_pkg::NUM_W;
   localparam int DEN_W    = tvp_pkg::DEN_W;
   localparam int LO_SHIFT = STEPS - FRACTION_BITS;

   logic [NUM_W-1:0] n_abs, n_top, n_frac;
   logic [DEN_W-1:0] d_abs;

   logic [DEN_W-1:0] p_in  [STEPS+1], p_ff  [STEPS+1];
   logic [DEN_W-1:0] d_ff  [STEPS+1];
   logic [STEPS-1:0] lo_in [STEPS+1], lo_ff [STEPS+1];
   logic [STEPS-1:0] q_in  [STEPS+1], q_ff  [STEPS+1];
   logic             neg_in, neg_ff [STEPS+1];
   logic             ovf_in, ovf_ff [STEPS+1];
   logic             v_ff [STEPS+1];
   logic [DEN_W:0]   pp, diff;
   logic             ge;

   logic [STEPS:0]   mag, lim, sat;
   tvp_pkg::coord_type quo_in, quo_ff;
   logic             vout_ff;

   // prepare magnitudes; quotient of 2^32 or more saturates
   always_comb begin
      n_abs  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      d_abs  = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
      n_top  = n_abs >> LO_SHIFT;
      n_frac = n_abs << FRACTION_BITS;
      neg_in = num[NUM_W-1] ^ den[DEN_W-1];
      ovf_in = n_top >= NUM_W'(d_abs);
      p_in[0]  = DEN_W'(n_top);
      lo_in[0] = n_frac[STEPS-1:0];
      q_in[0]  = '0;
      // one restoring step per stage
      for (int k = 0; k < STEPS; k++) begin
         pp   = {p_ff[k], lo_ff[k][STEPS-1]};
         ge   = pp >= {1'b0, d_ff[k]};
         diff = pp - {1'b0, d_ff[k]};
         p_in[k+1]  = ge ? diff[DEN_W-1:0] : pp[DEN_W-1:0];
         q_in[k+1]  = {q_ff[k][STEPS-2:0], ge};
         lo_in[k+1] = {lo_ff[k][STEPS-2:0], 1'b0};
      end
   end

   always_comb begin
      mag = ovf_ff[STEPS] ? {1'b0, {STEPS{1'b1}}} : {1'b0, q_ff[STEPS]};
      lim = neg_ff[STEPS] ? (STEPS+1)'(1) << (STEPS-1) : ((STEPS+1)'(1) << (STEPS-1)) - 1'b1;
      sat = (mag > lim) ? lim : mag;
      quo_in = neg_ff[STEPS] ? -tvp_pkg::coord_type'(sat[STEPS-1:0])
                             : tvp_pkg::coord_type'(sat[STEPS-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= STEPS; k++) v_ff[k] <= 1'b0;
         vout_ff <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
         for (int k = 1; k <= STEPS; k++) v_ff[k] <= v_ff[k-1];
         vout_ff <= v_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      d_ff[0]   <= d_abs;
      neg_ff[0] <= neg_in;
      ovf_ff[0] <= ovf_in;
      for (int k = 0; k <= STEPS; k++) begin
         p_ff[k]  <= p_in[k];
         lo_ff[k] <= lo_in[k];
         q_ff[k]  <= q_in[k];
      end
      for (int k = 1; k <= STEPS; k++) begin
         d_ff[k]   <= d_ff[k-1];
         neg_ff[k] <= neg_ff[k-1];
         ovf_ff[k] <= ovf_ff[k-1];
      end
      quo_ff <= quo_in;
   end

   assign out_valid = vout_ff;
   assign quo       = quo_ff;

endmodule

FILE: hw/rtl/triangle_view_projection.sv
// Projects one triangle per clock: each vertex is translated by the camera
// position, turned by the negative yaw and divided through -2z to screen
// coordinates, saturated to 32 bits. A triangle is taken whenever start is
// high (busy stays low) and its result appears on rsp_data with rsp_strobe
// after the translate, rotate and scale stages, the six bit-per-stage
// dividers (32 quotient bits) and a register for the window test.
// rsp_strobe lasts one cycle and cannot be held off, so the receiver must
// take every beat. CSR writes take effect at once and belong in idle time.
module triangle_view_projection #(
   parameter int SCREEN_WIDTH  = 600,
   parameter int SCREEN_HEIGHT = 600,
   parameter int GUARD_MARGIN  = 500,
   parameter int FRACTION_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  tvp_pkg::req_type                  req_data,
   output logic                              rsp_strobe,
   output tvp_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic [tvp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tvp_pkg::COORD_W-1:0]       csr_wdata
);

   localparam int WIN_W     = tvp_pkg::WIN_W;
   localparam int TOTAL_LAT = tvp_pkg::XFORM_LAT + tvp_pkg::DIV_LAT + 1;
   localparam tvp_pkg::coord_type ONE_K = tvp_pkg::coord_type'(1 << FRACTION_BITS);
   localparam logic signed [WIN_W-1:0] WIN_LO =
      -(WIN_W'(GUARD_MARGIN) <<< FRACTION_BITS);
   localparam logic signed [WIN_W-1:0] WIN_HX =
      WIN_W'(SCREEN_WIDTH + GUARD_MARGIN) <<< FRACTION_BITS;
   localparam logic signed [WIN_W-1:0] WIN_HY =
      WIN_W'(SCREEN_HEIGHT + GUARD_MARGIN) <<< FRACTION_BITS;

   tvp_pkg::cfg_type  cfg_ff;
   logic              accept;
   logic              xf_valid;
   tvp_pkg::proj_type xf_proj [3];
   tvp_pkg::side_type xf_side;
   tvp_pkg::side_type side_ff [tvp_pkg::DIV_LAT];
   logic [5:0]        dv_valid;
   tvp_pkg::coord_type dq [6];
   tvp_pkg::coord_type sc [6];
   logic [2:0]        inw;
   tvp_pkg::rsp_type  rsp_in, rsp_ff;
   logic              rsp_v_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.camera_x   <= '0;
         cfg_ff.camera_y   <= '0;
         cfg_ff.camera_z   <= tvp_pkg::coord_type'(5 << FRACTION_BITS);
         cfg_ff.yaw_cosine <= tvp_pkg::trig_type'(1 << tvp_pkg::YAW_BITS);
         cfg_ff.yaw_sine   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            tvp_pkg::CSR_CAMERA_X:   cfg_ff.camera_x   <= csr_wdata;
            tvp_pkg::CSR_CAMERA_Y:   cfg_ff.camera_y   <= csr_wdata;
            tvp_pkg::CSR_CAMERA_Z:   cfg_ff.camera_z   <= csr_wdata;
            tvp_pkg::CSR_YAW_COSINE: cfg_ff.yaw_cosine <= csr_wdata[tvp_pkg::TRIG_W-1:0];
            tvp_pkg::CSR_YAW_SINE:   cfg_ff.yaw_sine   <= csr_wdata[tvp_pkg::TRIG_W-1:0];
            default: ;
         endcase
      end
   end

   tvp_xform #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_xform (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_data   (req_data),
      .cfg       (cfg_ff),
      .out_valid (xf_valid),
      .out_proj  (xf_proj),
      .out_side  (xf_side)
   );

   for (genvar v = 0; v < 3; v++) begin : g_vertex
      tvp_divider #(.FRACTION_BITS(FRACTION_BITS)) u_div_x (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (xf_valid),
         .num       (xf_proj[v].num_x),
         .den       (xf_proj[v].den),
         .out_valid (dv_valid[2*v]),
         .quo       (dq[2*v])
      );
      tvp_divider #(.FRACTION_BITS(FRACTION_BITS)) u_div_y (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (xf_valid),
         .num       (xf_proj[v].num_y),
         .den       (xf_proj[v].den),
         .out_valid (dv_valid[2*v+1]),
         .quo       (dq[2*v+1])
      );
   end

   // flags ride alongside the dividers
   always_ff @(posedge clock) begin
      side_ff[0] <= xf_side;
      for (int k = 1; k < tvp_pkg::DIV_LAT; k++) side_ff[k] <= side_ff[k-1];
   end

   always_comb begin
      for (int v = 0; v < 3; v++) begin
         for (int a = 0; a < 2; a++) begin
            if (side_ff[tvp_pkg::DIV_LAT-1].behind) begin
               sc[2*v+a] = -ONE_K;
            end else if (side_ff[tvp_pkg::DIV_LAT-1].zero_den[v]) begin
               sc[2*v+a] = '0;
            end else begin
               sc[2*v+a] = dq[2*v+a];
            end
         end
         inw[v] = (WIN_W'(sc[2*v]) >= WIN_LO) && (WIN_W'(sc[2*v+1]) >= WIN_LO)
               && (WIN_W'(sc[2*v]) < WIN_HX) && (WIN_W'(sc[2*v+1]) < WIN_HY);
      end
      rsp_in.screen_a_x    = sc[0];
      rsp_in.screen_a_y    = sc[1];
      rsp_in.screen_b_x    = sc[2];
      rsp_in.screen_b_y    = sc[3];
      rsp_in.screen_c_x    = sc[4];
      rsp_in.screen_c_y    = sc[5];
      rsp_in.behind_camera = side_ff[tvp_pkg::DIV_LAT-1].behind;
      rsp_in.in_view       = (&inw) && (side_ff[tvp_pkg::DIV_LAT-1].behind
                             || !(|side_ff[tvp_pkg::DIV_LAT-1].zero_den));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else begin
         rsp_v_ff <= &dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_v_ff;
   assign rsp_data   = rsp_ff;

`ifndef SYNTHESIS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##TOTAL_LAT rsp_strobe)
      else $error("result beat missing after fixed latency");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, TOTAL_LAT))
      else $error("result beat without a triangle");

   a_behind: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.behind_camera |->
         rsp_data.screen_a_x == -ONE_K && rsp_data.screen_b_y == -ONE_K
         && rsp_data.screen_c_y == -ONE_K)
      else $error("behind-camera points not forced");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("strobe straight after reset");
`endif

endmodule
